FILE: rtl/voxel_capped_downsample_core_assert.svh
// assertion macros used by the voxel downsample back end
`ifndef VOXEL_CAPPED_DOWNSAMPLE_CORE_ASSERT_SVH
`define VOXEL_CAPPED_DOWNSAMPLE_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define VCD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define VCD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define VCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/vcd_pkg.sv
// shared types and constants of the voxel downsample core
package vcd_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 256;
    localparam int unsigned COORD_W           = 32;
    localparam int unsigned HITS_W            = 8;
    localparam int unsigned CFG_DATA_W        = 32;
    localparam int unsigned CFG_IDX_W         = 1;
    localparam int unsigned Q_DEPTH           = 2;
    localparam int unsigned ENTRY_W           = 2 * COORD_W + HITS_W;

    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_CELL  = 1'b1;

    localparam logic [COORD_W-1:0] INV_CELL_SIZE_RST = 32'h0001_0000;
    localparam logic [HITS_W-1:0]  MAX_PER_CELL_RST  = 8'd1;

    // point plus its grid cell, as it waits between front and back
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
        logic [COORD_W-1:0]        col;
        logic [COORD_W-1:0]        row;
    } t_cell_item;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [HITS_W-1:0]  hits;
    } t_tbl_entry;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FIN
    } t_back_state;

endpackage

FILE: rtl/vcd_ram.sv
// generic simple dual port ram with registered read
module vcd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/vcd_front.sv
// front end: accepts points and works out their grid cells
module vcd_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [vcd_pkg::COORD_W-1:0]       i_inv_cell_size,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [vcd_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [vcd_pkg::COORD_W-1:0] i_point_y,
    input  logic                              i_last_of_cloud,
    output logic                              o_push,
    output vcd_pkg::t_cell_item               o_item,
    input  logic                              i_q_full
);
    import vcd_pkg::*;

    localparam int unsigned PROD_W = 2 * COORD_W;

    // floor of the scaled coordinate: round the magnitude up for negatives
    function automatic logic [COORD_W-1:0] grid_finish(
        input logic              neg,
        input logic [PROD_W-1:0] prod
    );
        logic [COORD_W-1:0] q;
        q = prod[PROD_W-1:COORD_W] + COORD_W'(neg && (|prod[COORD_W-1:0]));
        return neg ? (COORD_W'(0) - q) : q;
    endfunction

    logic                      r1_vld;
    logic signed [COORD_W-1:0] r1_x;
    logic signed [COORD_W-1:0] r1_y;
    logic                      r1_last;

    logic                      r2_vld;
    logic signed [COORD_W-1:0] r2_x;
    logic signed [COORD_W-1:0] r2_y;
    logic                      r2_last;
    logic                      r2_negx;
    logic                      r2_negy;
    logic [PROD_W-1:0]         r2_prodx;
    logic [PROD_W-1:0]         r2_prody;

    logic                      push;
    logic                      adv2;
    logic                      accept;
    logic [COORD_W-1:0]        magx;
    logic [COORD_W-1:0]        magy;
    logic [PROD_W-1:0]         prodx;
    logic [PROD_W-1:0]         prody;

    assign push       = r2_vld && !i_q_full;
    assign adv2       = !r2_vld || push;
    assign o_in_ready = !r1_vld || adv2;
    assign accept     = i_in_valid && o_in_ready;

    // the most negative value negates to itself, which is its magnitude
    assign magx  = r1_x[COORD_W-1] ? (COORD_W'(0) - r1_x) : r1_x;
    assign magy  = r1_y[COORD_W-1] ? (COORD_W'(0) - r1_y) : r1_y;
    assign prodx = PROD_W'(magx) * PROD_W'(i_inv_cell_size);
    assign prody = PROD_W'(magy) * PROD_W'(i_inv_cell_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r1_vld <= i_in_valid;
            end
            if (adv2) begin
                r2_vld <= r1_vld;
            end
        end
        if (accept) begin
            r1_x    <= i_point_x;
            r1_y    <= i_point_y;
            r1_last <= i_last_of_cloud;
        end
        if (adv2 && r1_vld) begin
            r2_x     <= r1_x;
            r2_y     <= r1_y;
            r2_last  <= r1_last;
            r2_negx  <= r1_x[COORD_W-1];
            r2_negy  <= r1_y[COORD_W-1];
            r2_prodx <= prodx;
            r2_prody <= prody;
        end
    end

    assign o_push      = push;
    assign o_item.x    = r2_x;
    assign o_item.y    = r2_y;
    assign o_item.last = r2_last;
    assign o_item.col  = grid_finish(r2_negx, r2_prodx);
    assign o_item.row  = grid_finish(r2_negy, r2_prody);

endmodule

FILE: rtl/vcd_queue.sv
// short queue of classified points between front and back
module vcd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  vcd_pkg::t_cell_item i_item,
    output logic                o_full,
    output logic                o_valid,
    output vcd_pkg::t_cell_item o_item,
    input  logic                i_pop
);
    import vcd_pkg::*;

    localparam int unsigned PTR_W  = $clog2(Q_DEPTH);
    localparam int unsigned FILL_W = $clog2(Q_DEPTH + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(Q_DEPTH);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(Q_DEPTH - 1);

    t_cell_item        r_mem [Q_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - FILL_W'(1);
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_full  = (r_fill == FILL_MAX);
    assign o_valid = (r_fill != '0);
    assign o_item  = r_mem[r_rd_ptr];

endmodule

FILE: rtl/vcd_back.sv
// back end: cell table scan, hit update and result register
`include "voxel_capped_downsample_core_assert.svh"

module vcd_back #(
    parameter int unsigned TABLE_ENTRIES = vcd_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [vcd_pkg::HITS_W-1:0]         i_max_per_cell,
    input  logic                               i_q_valid,
    input  vcd_pkg::t_cell_item                i_q_item,
    output logic                               o_q_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [vcd_pkg::COORD_W-1:0] o_out_x,
    output logic signed [vcd_pkg::COORD_W-1:0] o_out_y,
    output logic                               o_keep,
    output logic                               o_table_full,
    output logic                               o_end_of_cloud
);
    import vcd_pkg::*;

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

    t_back_state               r_state, n_state;
    logic [CNT_W-1:0]          r_rd_idx, n_rd_idx;
    logic                      r_pend, n_pend;
    logic [IDX_W-1:0]          r_pend_idx, n_pend_idx;
    logic [CNT_W-1:0]          r_count, n_count;
    logic                      r_found, n_found;
    logic [IDX_W-1:0]          r_hit_idx, n_hit_idx;
    logic [HITS_W-1:0]         r_hit_cnt, n_hit_cnt;
    logic                      r_out_vld, n_out_vld;
    logic signed [COORD_W-1:0] r_out_x, n_out_x;
    logic signed [COORD_W-1:0] r_out_y, n_out_y;
    logic                      r_out_keep, n_out_keep;
    logic                      r_out_full, n_out_full;
    logic                      r_out_eoc, n_out_eoc;

    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    logic [IDX_W-1:0]          ram_raddr;
    t_tbl_entry                ram_wentry;
    logic [ENTRY_W-1:0]        ram_rdata;
    t_tbl_entry                rd_entry;

    logic                      match_now;
    logic                      scan_more;
    logic                      slot_free;
    logic                      below_cap;
    logic                      tbl_full;

    vcd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wentry),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry  = ram_rdata;
    // entries fill in index order, so the count bounds the valid ones
    assign scan_more = (r_rd_idx != r_count);
    assign match_now = r_pend && (rd_entry.col == i_q_item.col)
                              && (rd_entry.row == i_q_item.row);
    assign slot_free = !r_out_vld || i_out_ready;
    assign below_cap = (r_hit_cnt < i_max_per_cell);
    assign tbl_full  = (r_count == CNT_FULL);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (match_now || (!scan_more && !r_pend)) begin
                    n_state = BK_FIN;
                end
            end
            BK_FIN: begin
                if (slot_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        n_rd_idx        = r_rd_idx;
        n_pend          = r_pend;
        n_pend_idx      = r_pend_idx;
        n_count         = r_count;
        n_found         = r_found;
        n_hit_idx       = r_hit_idx;
        n_hit_cnt       = r_hit_cnt;
        n_out_vld       = r_out_vld && !i_out_ready;
        n_out_x         = r_out_x;
        n_out_y         = r_out_y;
        n_out_keep      = r_out_keep;
        n_out_full      = r_out_full;
        n_out_eoc       = r_out_eoc;
        o_q_pop         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = r_hit_idx;
        ram_raddr       = r_rd_idx[IDX_W-1:0];
        ram_wentry.col  = i_q_item.col;
        ram_wentry.row  = i_q_item.row;
        ram_wentry.hits = r_hit_cnt + HITS_W'(1);
        unique case (r_state)
            BK_IDLE: begin
                n_rd_idx = '0;
                n_pend   = 1'b0;
                n_found  = 1'b0;
            end
            BK_SCAN: begin
                // one read issued per cycle, compared when it returns
                n_pend     = scan_more && !match_now;
                n_pend_idx = r_rd_idx[IDX_W-1:0];
                if (scan_more && !match_now) begin
                    n_rd_idx = r_rd_idx + CNT_W'(1);
                end
                if (match_now) begin
                    n_found   = 1'b1;
                    n_hit_idx = r_pend_idx;
                    n_hit_cnt = rd_entry.hits;
                end
            end
            BK_FIN: begin
                if (slot_free) begin
                    o_q_pop   = 1'b1;
                    n_out_vld = 1'b1;
                    n_out_x   = i_q_item.x;
                    n_out_y   = i_q_item.y;
                    n_out_eoc = i_q_item.last;
                    if (r_found) begin
                        n_out_keep = below_cap;
                        n_out_full = 1'b0;
                        ram_we     = below_cap;
                    end else begin
                        n_out_keep      = 1'b1;
                        n_out_full      = tbl_full;
                        ram_we          = !tbl_full;
                        ram_waddr       = r_count[IDX_W-1:0];
                        ram_wentry.hits = HITS_W'(1);
                        if (!tbl_full) begin
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    if (i_q_item.last) begin
                        n_count = '0;
                    end
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_pend    <= 1'b0;
            r_count   <= '0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_count   <= n_count;
            r_found   <= n_found;
            r_out_vld <= n_out_vld;
        end
        r_rd_idx   <= n_rd_idx;
        r_pend_idx <= n_pend_idx;
        r_hit_idx  <= n_hit_idx;
        r_hit_cnt  <= n_hit_cnt;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_keep <= n_out_keep;
        r_out_full <= n_out_full;
        r_out_eoc  <= n_out_eoc;
    end

    assign o_out_valid    = r_out_vld;
    assign o_out_x        = r_out_x;
    assign o_out_y        = r_out_y;
    assign o_keep         = r_out_keep;
    assign o_table_full   = r_out_full;
    assign o_end_of_cloud = r_out_eoc;

    `VCD_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_FULL, "table fill count overran")
    `VCD_ASSERT_IMPL(a_read_in_fill, r_pend, CNT_W'(r_pend_idx) < r_count, "read of unfilled entry")
    `VCD_ASSERT_IMPL(a_write_in_fill, ram_we, CNT_W'(ram_waddr) <= r_count, "write past fill point")
    `VCD_ASSERT_NEXT(a_clear_on_last, o_q_pop && i_q_item.last, r_count == '0, "table not cleared")

endmodule

FILE: rtl/voxel_capped_downsample_core.sv
// top level of the capped voxel grid downsample core
//
//  channel   direction  handshake                   payload
//  config    in         i_cfg_we                    i_cfg_idx, i_cfg_data
//  point     in         i_in_valid / o_in_ready     i_point_x, i_point_y, i_last_of_cloud
//  result    out        o_out_valid / i_out_ready   o_out_x, o_out_y, o_keep,
//                                                   o_table_full, o_end_of_cloud
//
// the front takes a point per cycle, unless the queue is full, through a two stage grid
// pipeline; a taken point passes both stages before it is pushed into the two entry queue
// the back steps through an idle state, a table scan of one ram read per cycle and
// a result state before it returns to idle
// reset is synchronous active low and empties the table through its fill count
// front and back stall apart; a waiting result holds only the result state
module voxel_capped_downsample_core #(
    parameter int unsigned TABLE_ENTRIES = vcd_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [vcd_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [vcd_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [vcd_pkg::COORD_W-1:0]   i_point_x,
    input  logic signed [vcd_pkg::COORD_W-1:0]   i_point_y,
    input  logic                                 i_last_of_cloud,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [vcd_pkg::COORD_W-1:0]   o_out_x,
    output logic signed [vcd_pkg::COORD_W-1:0]   o_out_y,
    output logic                                 o_keep,
    output logic                                 o_table_full,
    output logic                                 o_end_of_cloud
);
    import vcd_pkg::*;

    logic [COORD_W-1:0] r_inv_cell_size;
    logic [HITS_W-1:0]  r_max_per_cell;

    logic               f_push;
    t_cell_item         f_item;
    logic               q_full;
    logic               q_valid;
    t_cell_item         q_item;
    logic               q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_cell_size <= INV_CELL_SIZE_RST;
            r_max_per_cell  <= MAX_PER_CELL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INV_CELL_SIZE: r_inv_cell_size <= i_cfg_data[COORD_W-1:0];
                CFG_MAX_PER_CELL:  r_max_per_cell  <= i_cfg_data[HITS_W-1:0];
            endcase
        end
    end

    vcd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_inv_cell_size (r_inv_cell_size),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_last_of_cloud (i_last_of_cloud),
        .o_push          (f_push),
        .o_item          (f_item),
        .i_q_full        (q_full)
    );

    vcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    vcd_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_max_per_cell (r_max_per_cell),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_keep         (o_keep),
        .o_table_full   (o_table_full),
        .o_end_of_cloud (o_end_of_cloud)
    );

endmodule

FILE: dv/tb_voxel_capped_downsample_core.sv
// self-checking testbench for the capped voxel grid downsample core
module tb_voxel_capped_downsample_core;
    timeunit 1ns;
    timeprecision 1ps;

    import vcd_pkg::*;

    localparam int unsigned NUM_CELLS       = TABLE_ENTRIES_DEF;
    localparam int unsigned BIG_CLOUD_LEN   = 300;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned PRINT_LIMIT     = 100;

    typedef enum int { CLOUD_PLAIN, CLOUD_DENSE, CLOUD_SPREAD } t_cloud_kind;
    typedef enum int { READY_ALWAYS, READY_MOSTLY, READY_COIN, READY_PERIODIC } t_ready_pattern;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               keep;
        logic               full;
        logic               last;
    } t_point_result;

    class voxel_scoreboard;
        logic [COORD_W-1:0] inv_scale;
        logic [HITS_W-1:0]  cap;
        logic [COORD_W-1:0] cell_x [NUM_CELLS];
        logic [COORD_W-1:0] cell_y [NUM_CELLS];
        logic [HITS_W-1:0]  cell_kept [NUM_CELLS];
        int unsigned        cells_used;
        t_point_result      expected_q [$];
        int unsigned        mismatches;

        function new();
            inv_scale  = INV_CELL_SIZE_RST;
            cap        = MAX_PER_CELL_RST;
            cells_used = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_INV_CELL_SIZE: inv_scale = data;
                CFG_MAX_PER_CELL:  cap = data[HITS_W-1:0];
                default: ;
            endcase
        endfunction

        // floor of the Q32.32 product; the magnitude stays below 2^63
        function logic [COORD_W-1:0] grid_cell(logic [COORD_W-1:0] coord);
            longint prod;
            prod = longint'($signed(coord)) * longint'({32'd0, inv_scale});
            return prod[63:32];
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic last);
            t_point_result      res;
            logic [COORD_W-1:0] col;
            logic [COORD_W-1:0] row;
            int                 hit;
            col  = grid_cell(x);
            row  = grid_cell(y);
            hit  = -1;
            for (int i = 0; i < cells_used; i++) begin
                if (hit < 0 && cell_x[i] == col && cell_y[i] == row)
                    hit = i;
            end
            res.x    = x;
            res.y    = y;
            res.last = last;
            res.keep = 1'b0;
            res.full = 1'b0;
            if (hit >= 0) begin
                if (cell_kept[hit] < cap) begin
                    cell_kept[hit] = cell_kept[hit] + 1'b1;
                    res.keep = 1'b1;
                end
            end else begin
                res.keep = 1'b1;
                if (cells_used < NUM_CELLS) begin
                    cell_x[cells_used]    = col;
                    cell_y[cells_used]    = row;
                    cell_kept[cells_used] = HITS_W'(1);
                    cells_used++;
                end else begin
                    res.full = 1'b1;
                end
            end
            expected_q.insert(expected_q.size(), res);
            if (last)
                cells_used = 0;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            if (mismatches < PRINT_LIMIT)
                $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
            mismatches++;
        endtask

        task check_result(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic keep,
                          logic full, logic last);
            t_point_result want;
            if (expected_q.size() == 0) begin
                report("result with no request outstanding", x, y);
                return;
            end
            want = expected_q.pop_front();
            if (x !== want.x)       report("out_x", x, want.x);
            if (y !== want.y)       report("out_y", y, want.y);
            if (keep !== want.keep) report("keep", keep, want.keep);
            if (full !== want.full) report("table_full", full, want.full);
            if (last !== want.last) report("end_of_cloud", last, want.last);
        endtask
    endclass

    logic                         i_clk           = 1'b0;
    logic                         i_rst_n         = 1'b0;
    logic                         i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_idx       = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data      = '0;
    logic                         i_in_valid      = 1'b0;
    logic                         o_in_ready;
    logic signed [COORD_W-1:0]    i_point_x       = '0;
    logic signed [COORD_W-1:0]    i_point_y       = '0;
    logic                         i_last_of_cloud = 1'b0;
    logic                         o_out_valid;
    logic                         i_out_ready     = 1'b0;
    logic signed [COORD_W-1:0]    o_out_x;
    logic signed [COORD_W-1:0]    o_out_y;
    logic                         o_keep;
    logic                         o_table_full;
    logic                         o_end_of_cloud;

    voxel_scoreboard sb;
    int unsigned     burst_left    = 0;
    bit              hold_off_req  = 1'b0;

    voxel_capped_downsample_core #(
        .TABLE_ENTRIES(NUM_CELLS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_last_of_cloud(i_last_of_cloud),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_keep         (o_keep),
        .o_table_full   (o_table_full),
        .o_end_of_cloud (o_end_of_cloud)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("** voxel_capped_downsample_core: FAILED **");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out_x, o_out_y, o_keep, o_table_full, o_end_of_cloud);
    end

    // result side: changing stall patterns, plus a long hold-off on request
    initial begin
        t_ready_pattern pattern;
        int unsigned    pattern_left;
        int unsigned    tick;
        pattern      = READY_ALWAYS;
        pattern_left = 0;
        tick         = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_ready  = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end else begin
                if (pattern_left == 0) begin
                    pattern      = t_ready_pattern'($urandom_range(0, 3));
                    pattern_left = $urandom_range(20, 80);
                end
                pattern_left--;
                tick++;
                case (pattern)
                    READY_ALWAYS:   i_out_ready = 1'b1;
                    READY_MOSTLY:   i_out_ready = ($urandom_range(0, 3) != 0);
                    READY_COIN:     i_out_ready = 1'($urandom_range(0, 1));
                    READY_PERIODIC: i_out_ready = ((tick % 7) < 3);
                    default:        i_out_ready = 1'b1;
                endcase
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    // bursts of requests with random gaps in between
    task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 40);
            if (gap != 0) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid      = 1'b1;
        i_point_x       = x;
        i_point_y       = y;
        i_last_of_cloud = last;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_point(x, y, last);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // mostly clustered around the origin so cells repeat, some full-range noise
    function automatic logic [COORD_W-1:0] pick_coord(int unsigned span);
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        return $urandom_range(0, 2 * span) - span;
    endfunction

    task automatic run_phase(input logic [31:0] inv_scale, input logic [7:0] cap,
                             input int unsigned count, input t_cloud_kind big,
                             input bit hold);
        int unsigned remaining;
        int unsigned len;
        int unsigned span;
        logic [31:0] x;
        logic [31:0] y;
        write_reg(CFG_INV_CELL_SIZE, inv_scale);
        write_reg(CFG_MAX_PER_CELL, {24'd0, cap});
        if (hold)
            hold_off_req = 1'b1;
        remaining = count;
        if (big != CLOUD_PLAIN) begin
            for (int k = 0; k < BIG_CLOUD_LEN; k++) begin
                if (big == CLOUD_DENSE) begin
                    x = $urandom_range(0, 32'h7FFF_FFFF);
                    y = $urandom_range(0, 32'h7FFF_FFFF);
                end else begin
                    // distinct cells overflow the table, then known and new ones mixed
                    x = (k < 270) ? (k << 16) : ($urandom_range(0, 299) << 16);
                    y = $urandom_range(0, 16'hFFFF);
                end
                send_point(x, y, k == BIG_CLOUD_LEN - 1);
            end
            remaining -= BIG_CLOUD_LEN;
        end
        while (remaining != 0) begin
            len  = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40);
            if (len > remaining)
                len = remaining;
            span = 1 << $urandom_range(4, 30);
            for (int k = 0; k < len; k++)
                send_point(pick_coord(span), pick_coord(span), k == len - 1);
            remaining -= len;
        end
        drain();
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: one point per cell, unit cells
        send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_point(32'h0000_FFFF, 32'h0000_FFFF, 1'b0);
        send_point(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h0001_0000, 32'hFFFF_0000, 1'b0);
        send_point(32'h0001_FFFF, 32'hFFFF_0001, 1'b0);
        send_point(32'hFFFF_0000, 32'h0001_0000, 1'b1);
        // table emptied after the marked point
        send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_point(32'h0000_0000, 32'h0000_0000, 1'b1);
        send_point(32'h0000_0000, 32'h0000_0000, 1'b1);
        drain();

        run_phase(32'h0001_0000, 8'd3, 180, CLOUD_PLAIN, 1'b1);
        run_phase(32'h0000_0001, 8'd255, 360, CLOUD_DENSE, 1'b0);
        run_phase(32'hFFFF_FFFF, 8'd2, 160, CLOUD_PLAIN, 1'b0);
        run_phase(32'h0000_0000, 8'd0, 120, CLOUD_PLAIN, 1'b0);
        run_phase($urandom(), 8'($urandom_range(1, 255)), 160, CLOUD_PLAIN, 1'b1);
        run_phase(32'h0001_0000, 8'd2, 330, CLOUD_SPREAD, 1'b0);
        run_phase(INV_CELL_SIZE_RST, MAX_PER_CELL_RST, 60, CLOUD_PLAIN, 1'b0);

        repeat (NUM_CELLS + 16) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report("results never produced", sb.pending(), 0);
        if (sb.mismatches == 0)
            $display("** voxel_capped_downsample_core: PASSED **");
        else
            $display("** voxel_capped_downsample_core: FAILED **");
        $finish;
    end

endmodule

FILE: voxel_capped_downsample_core.f
+incdir+rtl
rtl/vcd_pkg.sv
rtl/vcd_ram.sv
rtl/vcd_front.sv
rtl/vcd_queue.sv
rtl/vcd_back.sv
rtl/voxel_capped_downsample_core.sv
dv/tb_voxel_capped_downsample_core.sv
